// File: hdl/iqpcd_pkg.sv
`timescale 1ns / 1ps

package iqpcd_pkg;

	// Field and state widths
	localparam int SampleW  = 8;
	localparam int DcW      = 12;
	localparam int CentW    = 14;
	localparam int SqW      = 26;
	localparam int PowW     = 27;
	localparam int HoldW    = 16;
	localparam int OnW      = 20;
	localparam int WinW     = 31;
	localparam int NeedW    = 4;
	localparam int TimeW    = 32;

	// Click list
	localparam int MaxClicks = 8;
	localparam int SlotW     = (MaxClicks > 1) ? $clog2(MaxClicks) : 1;
	localparam int CountW    = $clog2(MaxClicks + 1);

	// Configuration port
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 31;

	// Output word queue
	localparam int QueueDepth = 8;
	localparam int QueuePtrW  = $clog2(QueueDepth);
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	localparam int InTdataW  = 16;
	localparam int OutTdataW = 32;

	localparam logic [OnW-1:0] OnMax = '1;

	typedef enum logic [CfgIdxW-1:0] {
		RegDcOffset       = 3'd0,
		RegPowerThreshold = 3'd1,
		RegHoldSamples    = 3'd2,
		RegMinOnSamples   = 3'd3,
		RegClickWindow    = 3'd4,
		RegClicksNeeded   = 3'd5
	} cfg_reg_t;

	// Per-sample tracking result handed to the click list.
	typedef struct packed {
		logic             detected;
		logic             signal_start;
		logic             signal_end;
		logic [OnW-1:0]   on_duration;
		logic             click;
		logic [TimeW-1:0] stamp;
	} track_t;

	// One output word; detected lands in bit 0.
	typedef struct packed {
		logic           activation;
		logic           click_event;
		logic [OnW-1:0] on_duration;
		logic           signal_end;
		logic           signal_start;
		logic           detected;
	} result_t;

	localparam int ResW = $bits(result_t);

endpackage

// File: hdl/iqpcd_power.sv
`timescale 1ns / 1ps

module iqpcd_power (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [iqpcd_pkg::SampleW-1:0] i_sample,
	input  logic [iqpcd_pkg::SampleW-1:0] q_sample,
	input  logic [iqpcd_pkg::DcW-1:0]     dc_offset,
	output logic                          valid_s2,
	output logic [iqpcd_pkg::PowW-1:0]    power_s2
);
	import iqpcd_pkg::*;

	logic                   valid_s1;
	logic [SampleW-1:0]     i_s1;
	logic [SampleW-1:0]     q_s1;
	logic signed [CentW-1:0] cent_i;
	logic signed [CentW-1:0] cent_q;
	logic signed [2*CentW-1:0] prod_i;
	logic signed [2*CentW-1:0] prod_q;
	logic [SqW-1:0]         sq_i_s2;
	logic [SqW-1:0]         sq_q_s2;

	// byte*16 - 2040 - dc_offset, in 1/16 LSB units
	function automatic logic signed [CentW-1:0] centre(
		input logic [SampleW-1:0] raw,
		input logic [DcW-1:0]     dc
	);
		logic signed [CentW-1:0] scaled;
		logic signed [CentW-1:0] dc_ext;
		scaled = $signed({{(CentW-SampleW-4){1'b0}}, raw, 4'b0000});
		dc_ext = CentW'($signed(dc));
		return scaled - CentW'(2040) - dc_ext;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			i_s1 <= i_sample;
			q_s1 <= q_sample;
		end
		sq_i_s2 <= prod_i[SqW-1:0];
		sq_q_s2 <= prod_q[SqW-1:0];
	end

	always_comb begin
		cent_i = centre(i_s1, dc_offset);
		cent_q = centre(q_s1, dc_offset);
		prod_i = cent_i * cent_i;
		prod_q = cent_q * cent_q;
	end

	assign power_s2 = {1'b0, sq_i_s2} + {1'b0, sq_q_s2};

endmodule

// File: hdl/iqpcd_track.sv
`timescale 1ns / 1ps

module iqpcd_track (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_s2,
	input  logic [iqpcd_pkg::PowW-1:0]  power_s2,
	input  logic [iqpcd_pkg::PowW-1:0]  power_threshold,
	input  logic [iqpcd_pkg::HoldW-1:0] hold_samples,
	input  logic [iqpcd_pkg::OnW-1:0]   min_on_samples,
	output logic                        valid_s3,
	output iqpcd_pkg::track_t           trk_s3
);
	import iqpcd_pkg::*;

	logic [TimeW-1:0] time_q;
	logic [HoldW-1:0] hold_q;
	logic [OnW-1:0]   on_q;
	logic             present_q;

	logic             above;
	logic             det;
	logic [HoldW-1:0] hold_n;
	logic [OnW-1:0]   on_n;
	track_t           trk;

	always_comb begin
		above  = power_s2 >= power_threshold;
		det    = 1'b1;
		hold_n = hold_q;
		on_n   = on_q;
		if (above) begin
			hold_n = hold_samples;
			if (on_q != OnMax) begin
				on_n = on_q + OnW'(1);
			end
		end else if (hold_q != '0) begin
			hold_n = hold_q - HoldW'(1);
		end else begin
			det = 1'b0;
		end
		if (!det) begin
			on_n = '0;
		end

		// A falling edge only happens on a weak sample, so on_q is the final count.
		trk.detected     = det;
		trk.signal_start = det && !present_q;
		trk.signal_end   = !det && present_q;
		trk.on_duration  = trk.signal_end ? on_q : '0;
		trk.click        = trk.signal_end && (on_q >= min_on_samples);
		trk.stamp        = time_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q    <= '0;
			hold_q    <= '0;
			on_q      <= '0;
			present_q <= 1'b0;
			valid_s3  <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			if (valid_s2) begin
				time_q    <= time_q + TimeW'(1);
				hold_q    <= hold_n;
				on_q      <= on_n;
				present_q <= det;
			end
		end
	end

	always_ff @(posedge clk) begin
		trk_s3 <= trk;
	end

endmodule

// File: hdl/iqpcd_clicks.sv
`timescale 1ns / 1ps

module iqpcd_clicks (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_s3,
	input  iqpcd_pkg::track_t           trk_s3,
	input  logic [iqpcd_pkg::WinW-1:0]  click_window,
	input  logic [iqpcd_pkg::NeedW-1:0] clicks_needed,
	output logic                        out_valid,
	output iqpcd_pkg::result_t          out_res
);
	import iqpcd_pkg::*;

	localparam int Leaves = 1 << SlotW;
	localparam int CmpW   = (CountW > NeedW) ? CountW : NeedW;

	logic [TimeW-1:0]     stamps_q [MaxClicks];
	logic [MaxClicks-1:0] cvalid_q;

	logic [TimeW-1:0]     age      [MaxClicks];
	logic [MaxClicks-1:0] keep;

	logic                 valid_s4;
	track_t               trk_s4;
	logic [TimeW-1:0]     age_s4   [MaxClicks];
	logic [MaxClicks-1:0] keep_s4;

	logic [SlotW-1:0]     node_idx [2*Leaves];
	logic [TimeW-1:0]     node_age [2*Leaves];
	logic                 node_vld [2*Leaves];

	logic                 any_free;
	logic [SlotW-1:0]     free_idx;
	logic [SlotW-1:0]     slot;
	logic [CountW-1:0]    count;
	logic                 act;
	logic                 do_click;
	logic [MaxClicks-1:0] cvalid_n;

	// Stage 3: ages against the stamp of this sample, and the prune decision.
	always_comb begin
		for (int k = 0; k < MaxClicks; k++) begin
			age[k]  = trk_s3.stamp - stamps_q[k];
			keep[k] = cvalid_q[k] && (age[k] <= {1'b0, click_window});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		trk_s4  <= trk_s3;
		keep_s4 <= keep;
		for (int k = 0; k < MaxClicks; k++) begin
			age_s4[k] <= age[k];
		end
	end

	// Stage 4: pick the slot, count the clicks and update the list.
	// Signal ends are at least two samples apart, so the list written here is
	// settled before the next click reaches stage 3.
	always_comb begin
		for (int n = 0; n < 2*Leaves; n++) begin
			node_idx[n] = '0;
			node_age[n] = '0;
			node_vld[n] = 1'b0;
		end
		for (int k = 0; k < Leaves; k++) begin
			node_idx[Leaves+k] = SlotW'(k);
			if (k < MaxClicks) begin
				node_age[Leaves+k] = age_s4[k];
				node_vld[Leaves+k] = keep_s4[k];
			end
		end
		// Oldest kept click; on equal ages the lower index wins.
		for (int n = Leaves - 1; n >= 1; n--) begin
			if (node_vld[2*n+1] && (!node_vld[2*n] || node_age[2*n+1] > node_age[2*n])) begin
				node_idx[n] = node_idx[2*n+1];
				node_age[n] = node_age[2*n+1];
				node_vld[n] = 1'b1;
			end else begin
				node_idx[n] = node_idx[2*n];
				node_age[n] = node_age[2*n];
				node_vld[n] = node_vld[2*n];
			end
		end

		any_free = 1'b0;
		free_idx = '0;
		count    = '0;
		for (int k = 0; k < MaxClicks; k++) begin
			if (!keep_s4[k] && !any_free) begin
				any_free = 1'b1;
				free_idx = SlotW'(k);
			end
			count = count + CountW'(keep_s4[k]);
		end
		if (any_free) begin
			count = count + CountW'(1);
		end
		slot = any_free ? free_idx : node_idx[1];

		do_click = valid_s4 && trk_s4.click;
		act      = do_click && (CmpW'(count) >= CmpW'(clicks_needed));

		cvalid_n = keep_s4;
		cvalid_n[slot] = 1'b1;
		if (act) begin
			cvalid_n = '0;
		end

		out_valid               = valid_s4;
		out_res.detected        = trk_s4.detected;
		out_res.signal_start    = trk_s4.signal_start;
		out_res.signal_end      = trk_s4.signal_end;
		out_res.on_duration     = trk_s4.on_duration;
		out_res.click_event     = trk_s4.click;
		out_res.activation      = act;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvalid_q <= '0;
		end else if (do_click) begin
			cvalid_q <= cvalid_n;
		end
	end

	always_ff @(posedge clk) begin
		if (do_click) begin
			stamps_q[slot] <= trk_s4.stamp;
		end
	end

endmodule

// File: hdl/iqpcd_queue.sv
`timescale 1ns / 1ps

module iqpcd_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  iqpcd_pkg::result_t       push_res,
	input  logic                     pop,
	output logic                     head_valid,
	output iqpcd_pkg::result_t       head_res
);
	import iqpcd_pkg::*;

	result_t              mem_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_q;
	logic [QueuePtrW-1:0] rd_q;
	logic [QueueCntW-1:0] cnt_q;

	function automatic logic [QueuePtrW-1:0] bump(input logic [QueuePtrW-1:0] p);
		return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + QueuePtrW'(1);
	endfunction

	assign head_valid = cnt_q != '0;
	assign head_res   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QueueCntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QueueCntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_res;
		end
	end

endmodule

// File: hdl/iq_power_click_detector_core.sv
`timescale 1ns / 1ps

// IQ power click detector. Each input word carries one raw unsigned I/Q byte pair and yields
// exactly one output word with the detection flags, the on-time at a signal end, the click
// flag and the activation flag. While s_axis_tready is high, one word is taken every clock
// cycle; a result is offered on the output behind a four-stage pipeline (input register,
// squares, detection state, click list) and the output queue. An eight-word output queue
// decouples the two sides: s_axis_tready drops only when eight words are in flight or
// waiting, so a stalled output stops the input after at most eight words. Configuration
// writes take effect at once and are meant for times when no word is in flight.

module iq_power_click_detector_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [7:0] i_sample, [15:8] q_sample
	input  logic [iqpcd_pkg::InTdataW-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [0] detected, [1] signal_start, [2] signal_end, [22:3] on_duration,
	// [23] click_event, [24] activation, [31:25] zero
	output logic [iqpcd_pkg::OutTdataW-1:0] m_axis_tdata,
	input  logic                           cfg_we,
	input  logic [iqpcd_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [iqpcd_pkg::CfgDataW-1:0]  cfg_data
);
	import iqpcd_pkg::*;

	logic [DcW-1:0]   dc_offset_q;
	logic [PowW-1:0]  power_threshold_q;
	logic [HoldW-1:0] hold_samples_q;
	logic [OnW-1:0]   min_on_samples_q;
	logic [WinW-1:0]  click_window_q;
	logic [NeedW-1:0] clicks_needed_q;

	logic                 in_accept;
	logic                 out_accept;
	logic [QueueCntW-1:0] used_q;

	logic            valid_s2;
	logic [PowW-1:0] power_s2;
	logic            valid_s3;
	track_t          trk_s3;
	logic            res_valid;
	result_t         res;
	logic            head_valid;
	result_t         head_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_offset_q       <= '0;
			power_threshold_q <= PowW'(5280);
			hold_samples_q    <= HoldW'(4800);
			min_on_samples_q  <= OnW'(12000);
			click_window_q    <= WinW'(1200000);
			clicks_needed_q   <= NeedW'(5);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				RegDcOffset:       dc_offset_q       <= cfg_data[DcW-1:0];
				RegPowerThreshold: power_threshold_q <= cfg_data[PowW-1:0];
				RegHoldSamples:    hold_samples_q    <= cfg_data[HoldW-1:0];
				RegMinOnSamples:   min_on_samples_q  <= cfg_data[OnW-1:0];
				RegClickWindow:    click_window_q    <= cfg_data[WinW-1:0];
				RegClicksNeeded:   clicks_needed_q   <= cfg_data[NeedW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Every word taken holds a queue slot until its result leaves, so the
	// pipeline itself never stalls.
	assign s_axis_tready = used_q != QueueCntW'(QueueDepth);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_accept    = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (in_accept && !out_accept) begin
			used_q <= used_q + QueueCntW'(1);
		end else if (out_accept && !in_accept) begin
			used_q <= used_q - QueueCntW'(1);
		end
	end

	iqpcd_power u_power (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_accept),
		.i_sample  (s_axis_tdata[SampleW-1:0]),
		.q_sample  (s_axis_tdata[2*SampleW-1:SampleW]),
		.dc_offset (dc_offset_q),
		.valid_s2  (valid_s2),
		.power_s2  (power_s2)
	);

	iqpcd_track u_track (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s2        (valid_s2),
		.power_s2        (power_s2),
		.power_threshold (power_threshold_q),
		.hold_samples    (hold_samples_q),
		.min_on_samples  (min_on_samples_q),
		.valid_s3        (valid_s3),
		.trk_s3          (trk_s3)
	);

	iqpcd_clicks u_clicks (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s3      (valid_s3),
		.trk_s3        (trk_s3),
		.click_window  (click_window_q),
		.clicks_needed (clicks_needed_q),
		.out_valid     (res_valid),
		.out_res       (res)
	);

	iqpcd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_res   (res),
		.pop        (out_accept),
		.head_valid (head_valid),
		.head_res   (head_res)
	);

	assign m_axis_tvalid = head_valid;
	assign m_axis_tdata  = {{(OutTdataW-ResW){1'b0}}, head_res};

endmodule
